// File: hdl/fsr_pkg.sv
// fsr_pkg: shared types, constants and the binary32 unpack helper
// used by the multiplier, adder and reciprocal units of the square root pipeline
// no dependencies
`timescale 1ns / 1ps

package fsr_pkg;

  // inverse-root seed constant and float constants as bit patterns
  localparam logic [31:0] MagicConst    = 32'h5f3759df;
  localparam logic [31:0] HalfBits      = 32'h3f000000;
  localparam logic [31:0] ThreeHalfBits = 32'h3fc00000;
  localparam logic [31:0] QnanBits      = 32'h7fc00000;
  localparam logic [7:0]  ExpMax        = 8'hff;

  // unpacked binary32 operand, subnormals carry exponent 1 and no hidden bit
  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] mant;
    logic        zero;
    logic        inf;
    logic        nan;
  } fp_t;

  // side data that travels with an item through the arithmetic units
  typedef struct packed {
    logic        zero_in;
    logic [31:0] h;
    logic [31:0] r;
  } side_t;

  function automatic fp_t unpack(input logic [31:0] b);
    fp_t f;
    f.sign = b[31];
    f.exp  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    f.mant = {(b[30:23] != 8'd0), b[22:0]};
    f.zero = (b[30:0] == 31'd0);
    f.inf  = (b[30:23] == ExpMax) && (b[22:0] == 23'd0);
    f.nan  = (b[30:23] == ExpMax) && (b[22:0] != 23'd0);
    return f;
  endfunction

endpackage

// File: hdl/fsr_fmul.sv
// fsr_fmul: four-stage binary32 multiplier, round to nearest even, subnormals kept
// carries a side_t beat alongside the product; depends on fsr_pkg
`timescale 1ns / 1ps

module fsr_fmul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  fsr_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [31:0]         res_o,
  output fsr_pkg::side_t      side_o
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  fsr_pkg::fp_t ua, ub;

  // stage 1: unpack, special values, mantissa product
  logic                  s1_vld_q;
  logic                  s1_sign_q, s1_spec_q;
  logic [31:0]           s1_sval_q;
  logic [47:0]           s1_prod_q;
  logic signed [10:0]    s1_e1_q;
  fsr_pkg::side_t        s1_side_q;
  logic                  spec_d;
  logic [31:0]           sval_d;

  assign ua = fsr_pkg::unpack(a_i);
  assign ub = fsr_pkg::unpack(b_i);

  always_comb begin
    spec_d = ua.nan | ub.nan | ua.inf | ub.inf | ua.zero | ub.zero;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      sval_d = fsr_pkg::QnanBits;
    end else if (ua.inf || ub.inf) begin
      sval_d = {ua.sign ^ ub.sign, fsr_pkg::ExpMax, 23'd0};
    end else begin
      sval_d = {ua.sign ^ ub.sign, 31'd0};
    end
  end

  // stage 2: leading zero count and shift amount
  logic                  s2_vld_q;
  logic                  s2_sign_q, s2_spec_q;
  logic [31:0]           s2_sval_q;
  logic [47:0]           s2_prod_q;
  logic signed [10:0]    s2_e1_q, s2_k_q;
  fsr_pkg::side_t        s2_side_q;
  logic [5:0]            lz;
  logic signed [10:0]    e1m1, lz_s, k_d;

  always_comb begin
    lz   = lzc48(s1_prod_q);
    lz_s = $signed({5'd0, lz});
    e1m1 = s1_e1_q - 11'sd1;
    k_d  = (e1m1 < lz_s) ? e1m1 : lz_s;
  end

  // stage 3: normalize left, or shift right into the subnormal range
  logic                  s3_vld_q;
  logic                  s3_sign_q, s3_spec_q, s3_stx_q;
  logic [31:0]           s3_sval_q;
  logic [47:0]           s3_norm_q;
  logic signed [10:0]    s3_expv_q;
  fsr_pkg::side_t        s3_side_q;
  logic [95:0]           ext;
  logic [10:0]           rsh;
  logic [47:0]           norm_d;
  logic                  stx_d;

  always_comb begin
    ext    = 96'd0;
    rsh    = 11'd0 - s2_k_q;
    norm_d = 48'd0;
    stx_d  = 1'b0;
    if (!s2_k_q[10]) begin
      norm_d = s2_prod_q << s2_k_q[5:0];
    end else if (rsh >= 11'd48) begin
      stx_d = |s2_prod_q;
    end else begin
      ext    = {s2_prod_q, 48'd0} >> rsh[5:0];
      norm_d = ext[95:48];
      stx_d  = |ext[47:0];
    end
  end

  // stage 4: round and pack
  logic                  s4_vld_q;
  logic [31:0]           s4_res_q;
  fsr_pkg::side_t        s4_side_q;
  logic                  g, st, ru, ovf;
  logic [7:0]            field;
  logic [30:0]           packed_d;
  logic [31:0]           res_d;

  always_comb begin
    g        = s3_norm_q[23];
    st       = (|s3_norm_q[22:0]) | s3_stx_q;
    ru       = g & (st | s3_norm_q[24]);
    ovf      = s3_norm_q[47] && (s3_expv_q > 11'sd254);
    field    = s3_norm_q[47] ? s3_expv_q[7:0] : 8'd0;
    packed_d = {field, s3_norm_q[46:24]} + {30'd0, ru};
    if (s3_spec_q) res_d = s3_sval_q;
    else if (ovf) res_d = {s3_sign_q, fsr_pkg::ExpMax, 23'd0};
    else res_d = {s3_sign_q, packed_d};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= ua.sign ^ ub.sign;
      s1_spec_q <= spec_d;
      s1_sval_q <= sval_d;
      s1_prod_q <= ua.mant * ub.mant;
      s1_e1_q   <= $signed({3'd0, ua.exp}) + $signed({3'd0, ub.exp}) - 11'sd126;
      s1_side_q <= side_i;

      s2_sign_q <= s1_sign_q;
      s2_spec_q <= s1_spec_q;
      s2_sval_q <= s1_sval_q;
      s2_prod_q <= s1_prod_q;
      s2_e1_q   <= s1_e1_q;
      s2_k_q    <= k_d;
      s2_side_q <= s1_side_q;

      s3_sign_q <= s2_sign_q;
      s3_spec_q <= s2_spec_q;
      s3_sval_q <= s2_sval_q;
      s3_norm_q <= norm_d;
      s3_stx_q  <= stx_d;
      s3_expv_q <= s2_e1_q - s2_k_q;
      s3_side_q <= s2_side_q;

      s4_res_q  <= res_d;
      s4_side_q <= s3_side_q;
    end
  end

  assign valid_o = s4_vld_q;
  assign res_o   = s4_res_q;
  assign side_o  = s4_side_q;

endmodule

// File: hdl/fsr_fadd.sv
// fsr_fadd: four-stage binary32 adder, round to nearest even, subnormals kept
// carries a side_t beat alongside the sum; depends on fsr_pkg
`timescale 1ns / 1ps

module fsr_fadd (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         a_i,
  input  logic [31:0]         b_i,
  input  fsr_pkg::side_t      side_i,
  output logic                valid_o,
  output logic [31:0]         res_o,
  output fsr_pkg::side_t      side_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd0;
    found = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  fsr_pkg::fp_t ua, ub, big, lit;

  // stage 1: specials, order operands by magnitude, align the smaller one
  logic                  s1_vld_q;
  logic                  s1_sign_q, s1_sub_q, s1_spec_q;
  logic [31:0]           s1_sval_q;
  logic [23:0]           s1_ma_q;
  logic [26:0]           s1_bal_q;
  logic [7:0]            s1_ea_q;
  fsr_pkg::side_t        s1_side_q;
  logic                  swap, spec_d;
  logic [7:0]            d;
  logic [53:0]           ash;
  logic [26:0]           bal_d;
  logic [31:0]           sval_d;

  assign ua = fsr_pkg::unpack(a_i);
  assign ub = fsr_pkg::unpack(b_i);

  always_comb begin
    swap  = (ub.exp > ua.exp) || ((ub.exp == ua.exp) && (ub.mant > ua.mant));
    big   = swap ? ub : ua;
    lit   = swap ? ua : ub;
    d     = big.exp - lit.exp;
    ash   = 54'd0;
    if (d >= 8'd27) begin
      bal_d = {26'd0, |lit.mant};
    end else begin
      ash   = {lit.mant, 3'd0, 27'd0} >> d[4:0];
      bal_d = ash[53:27] | {26'd0, |ash[26:0]};
    end
    spec_d = ua.nan | ub.nan | ua.inf | ub.inf | ua.zero | ub.zero;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign))) sval_d = fsr_pkg::QnanBits;
    else if (ua.inf) sval_d = a_i;
    else if (ub.inf) sval_d = b_i;
    else if (ua.zero && ub.zero) sval_d = {ua.sign & ub.sign, 31'd0};
    else if (ua.zero) sval_d = b_i;
    else sval_d = a_i;
  end

  // stage 2: add or subtract magnitudes, count leading zeros
  logic                  s2_vld_q;
  logic                  s2_sign_q, s2_spec_q;
  logic [31:0]           s2_sval_q;
  logic [27:0]           s2_sum_q;
  logic [4:0]            s2_lz_q;
  logic [7:0]            s2_ea_q;
  fsr_pkg::side_t        s2_side_q;
  logic [27:0]           sum_d;

  always_comb begin
    if (s1_sub_q) sum_d = {1'b0, s1_ma_q, 3'd0} - {1'b0, s1_bal_q};
    else sum_d = {1'b0, s1_ma_q, 3'd0} + {1'b0, s1_bal_q};
  end

  // stage 3: normalize, limited so the exponent stays at or above one
  logic                  s3_vld_q;
  logic                  s3_sign_q, s3_spec_q, s3_zero_q;
  logic [31:0]           s3_sval_q;
  logic [26:0]           s3_norm_q;
  logic [8:0]            s3_expv_q;
  fsr_pkg::side_t        s3_side_q;
  logic [7:0]            em1, k;
  logic [26:0]           norm_d;
  logic [8:0]            expv_d;

  always_comb begin
    em1 = s2_ea_q - 8'd1;
    k   = ({3'd0, s2_lz_q} <= em1) ? {3'd0, s2_lz_q} : em1;
    if (s2_sum_q[27]) begin
      norm_d = {s2_sum_q[27:2], s2_sum_q[1] | s2_sum_q[0]};
      expv_d = {1'b0, s2_ea_q} + 9'd1;
    end else begin
      norm_d = s2_sum_q[26:0] << k[4:0];
      expv_d = {1'b0, s2_ea_q} - {1'b0, k};
    end
  end

  // stage 4: round and pack
  logic                  s4_vld_q;
  logic [31:0]           s4_res_q;
  fsr_pkg::side_t        s4_side_q;
  logic                  g, st, ru, ovf;
  logic [7:0]            field;
  logic [30:0]           packed_d;
  logic [31:0]           res_d;

  always_comb begin
    g        = s3_norm_q[2];
    st       = |s3_norm_q[1:0];
    ru       = g & (st | s3_norm_q[3]);
    ovf      = s3_norm_q[26] && (s3_expv_q >= 9'd255);
    field    = s3_norm_q[26] ? s3_expv_q[7:0] : 8'd0;
    packed_d = {field, s3_norm_q[25:3]} + {30'd0, ru};
    if (s3_spec_q) res_d = s3_sval_q;
    else if (s3_zero_q) res_d = 32'd0;
    else if (ovf) res_d = {s3_sign_q, fsr_pkg::ExpMax, 23'd0};
    else res_d = {s3_sign_q, packed_d};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= big.sign;
      s1_sub_q  <= ua.sign ^ ub.sign;
      s1_spec_q <= spec_d;
      s1_sval_q <= sval_d;
      s1_ma_q   <= big.mant;
      s1_bal_q  <= bal_d;
      s1_ea_q   <= big.exp;
      s1_side_q <= side_i;

      s2_sign_q <= s1_sign_q;
      s2_spec_q <= s1_spec_q;
      s2_sval_q <= s1_sval_q;
      s2_sum_q  <= sum_d;
      s2_lz_q   <= lzc27(sum_d[26:0]);
      s2_ea_q   <= s1_ea_q;
      s2_side_q <= s1_side_q;

      s3_sign_q <= s2_sign_q;
      s3_spec_q <= s2_spec_q;
      s3_sval_q <= s2_sval_q;
      s3_zero_q <= (s2_sum_q == 28'd0);
      s3_norm_q <= norm_d;
      s3_expv_q <= expv_d;
      s3_side_q <= s2_side_q;

      s4_res_q  <= res_d;
      s4_side_q <= s3_side_q;
    end
  end

  assign valid_o = s4_vld_q;
  assign res_o   = s4_res_q;
  assign side_o  = s4_side_q;

endmodule

// File: hdl/fsr_frcp.sv
// fsr_frcp: pipelined binary32 reciprocal, one quotient bit per stage,
// round to nearest even, subnormals kept; depends on fsr_pkg
`timescale 1ns / 1ps

module fsr_frcp (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [31:0]  r_i,
  input  logic         zero_in_i,
  output logic         valid_o,
  output logic [31:0]  res_o
);

  localparam int DivSteps = 27;

  typedef enum logic [1:0] {
    SpNone = 2'd0,
    SpNan  = 2'd1,
    SpZero = 2'd2,
    SpInf  = 2'd3
  } spec_e;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n     = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  // entry: specials and divisor normalization
  fsr_pkg::fp_t       ur;
  spec_e              sp_d;
  logic [4:0]         lz;
  logic signed [9:0]  er;

  assign ur = fsr_pkg::unpack(r_i);

  always_comb begin
    lz = lzc24(ur.mant);
    er = $signed({2'd0, ur.exp}) - $signed({5'd0, lz});
    if (zero_in_i) sp_d = SpZero;
    else if (ur.nan) sp_d = SpNan;
    else if (ur.inf) sp_d = SpZero;
    else if (ur.zero) sp_d = SpInf;
    else sp_d = SpNone;
  end

  // divider stages, index 0 is the entry register
  logic               vld_q  [0:DivSteps];
  logic               sgn_q  [0:DivSteps];
  spec_e              sp_q   [0:DivSteps];
  logic signed [9:0]  eq_q   [0:DivSteps];
  logic [23:0]        m_q    [0:DivSteps];
  logic [24:0]        rem_q  [0:DivSteps];
  logic [26:0]        quo_q  [0:DivSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn_q[0] <= zero_in_i ? 1'b0 : ur.sign;
      sp_q[0]  <= sp_d;
      eq_q[0]  <= 10'sd254 - er;
      m_q[0]   <= ur.mant << lz;
      rem_q[0] <= 25'h0800000;
      quo_q[0] <= 27'd0;
    end
  end

  for (genvar i = 1; i <= DivSteps; i++) begin : g_div
    logic        ge;
    logic [24:0] rnx;

    // one restoring step: compare, subtract, shift
    always_comb begin
      ge  = (rem_q[i-1] >= {1'b0, m_q[i-1]});
      rnx = ge ? (rem_q[i-1] - {1'b0, m_q[i-1]}) : rem_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sgn_q[i] <= sgn_q[i-1];
        sp_q[i]  <= sp_q[i-1];
        eq_q[i]  <= eq_q[i-1];
        m_q[i]   <= m_q[i-1];
        rem_q[i] <= {rnx[23:0], 1'b0};
        quo_q[i] <= {quo_q[i-1][25:0], ge};
      end
    end
  end

  // first output stage: align quotient, move into subnormal range if needed
  logic               f1_vld_q, f1_sgn_q, f1_g_q, f1_st_q, f1_ovf_q;
  spec_e              f1_sp_q;
  logic [23:0]        f1_m_q;
  logic [7:0]         f1_field_q;
  logic [23:0]        m24, m24s;
  logic               g0, st0, gs, sts;
  logic signed [9:0]  expv;
  logic [9:0]         rsh;
  logic [4:0]         sh5;
  logic [49:0]        ext;

  always_comb begin
    if (quo_q[DivSteps][26]) begin
      m24  = quo_q[DivSteps][26:3];
      g0   = quo_q[DivSteps][2];
      st0  = (|quo_q[DivSteps][1:0]) | (rem_q[DivSteps] != 25'd0);
      expv = eq_q[DivSteps];
    end else begin
      m24  = quo_q[DivSteps][25:2];
      g0   = quo_q[DivSteps][1];
      st0  = quo_q[DivSteps][0] | (rem_q[DivSteps] != 25'd0);
      expv = eq_q[DivSteps] - 10'sd1;
    end
    rsh  = 10'd1 - expv;
    sh5  = (rsh > 10'd26) ? 5'd26 : rsh[4:0];
    ext  = 50'd0;
    m24s = m24;
    gs   = g0;
    sts  = st0;
    if (expv < 10'sd1) begin
      ext  = {m24, g0, 25'd0} >> sh5;
      m24s = ext[49:26];
      gs   = ext[25];
      sts  = st0 | (|ext[24:0]);
    end
  end

  // second output stage: round, pack, specials
  logic               f2_vld_q;
  logic [31:0]        f2_res_q;
  logic               ru;
  logic [30:0]        packed_d;
  logic [31:0]        res_d;

  always_comb begin
    ru       = f1_g_q & (f1_st_q | f1_m_q[0]);
    packed_d = {f1_field_q, f1_m_q[22:0]} + {30'd0, ru};
    case (f1_sp_q)
      SpNan:   res_d = fsr_pkg::QnanBits;
      SpZero:  res_d = {f1_sgn_q, 31'd0};
      SpInf:   res_d = {f1_sgn_q, fsr_pkg::ExpMax, 23'd0};
      default: res_d = f1_ovf_q ? {f1_sgn_q, fsr_pkg::ExpMax, 23'd0} : {f1_sgn_q, packed_d};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en_i) begin
      f1_vld_q <= vld_q[DivSteps];
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_sgn_q   <= sgn_q[DivSteps];
      f1_sp_q    <= sp_q[DivSteps];
      f1_m_q     <= m24s;
      f1_g_q     <= gs;
      f1_st_q    <= sts;
      f1_ovf_q   <= (expv > 10'sd254);
      f1_field_q <= (expv < 10'sd1) ? 8'd0 : expv[7:0];
      f2_res_q   <= res_d;
    end
  end

  assign valid_o = f2_vld_q;
  assign res_o   = f2_res_q;

endmodule

// File: hdl/fast_square_root_float.sv
// fast_square_root_float: approximate binary32 square root through an
// inverse-root seed, two refinement steps and a reciprocal; uses fsr_pkg,
// fsr_fmul, fsr_fadd and fsr_frcp
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-------------------
//   in      | in_valid_i   | in_stall_o   | x_bits_i[31:0]
//   out     | out_valid_o  | out_stall_i  | root_bits_o[31:0]
//
// one beat enters per cycle unless out_stall_i holds the pipeline; it runs
// through seven multipliers of 4 stages, two adders of 4 stages and a 30-stage
// reciprocal whose 27 one-bit divide steps set most of its depth.
// reset clears only the valid bits; the payload registers are not reset.
// the whole pipeline freezes while a result waits on out_stall_i, so in_stall_o
// rises only then and no beat is lost or repeated.
`timescale 1ns / 1ps

module fast_square_root_float (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  x_bits_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  root_bits_o
);

  logic en;

  // global advance, held while the output beat is refused
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  // seed estimate from the bit pattern
  logic [31:0]     shifted;
  fsr_pkg::side_t  side0;

  assign shifted = {x_bits_i[31], x_bits_i[31:1]};
  assign side0   = '{zero_in: (x_bits_i[30:0] == 31'd0), h: 32'd0,
                     r: fsr_pkg::MagicConst - shifted};

  // h = 0.5 * x
  logic            v_h;
  logic [31:0]     h_res;
  fsr_pkg::side_t  s_h, side1;

  fsr_fmul u_mul_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .a_i(x_bits_i),
    .b_i(fsr_pkg::HalfBits), .side_i(side0), .valid_o(v_h), .res_o(h_res), .side_o(s_h)
  );

  assign side1 = '{zero_in: s_h.zero_in, h: h_res, r: s_h.r};

  // first refinement step
  logic            v_a1, v_a2, v_a3, v_a4;
  logic [31:0]     t_a1, t_a2, t_a3, r1;
  fsr_pkg::side_t  s_a1, s_a2, s_a3, s_a4, side2;

  fsr_fmul u_mul_a1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_h), .a_i(side1.h), .b_i(side1.r),
    .side_i(side1), .valid_o(v_a1), .res_o(t_a1), .side_o(s_a1)
  );

  fsr_fmul u_mul_a2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_a1), .a_i(t_a1), .b_i(s_a1.r),
    .side_i(s_a1), .valid_o(v_a2), .res_o(t_a2), .side_o(s_a2)
  );

  fsr_fadd u_add_a (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_a2), .a_i(fsr_pkg::ThreeHalfBits),
    .b_i({~t_a2[31], t_a2[30:0]}), .side_i(s_a2), .valid_o(v_a3), .res_o(t_a3),
    .side_o(s_a3)
  );

  fsr_fmul u_mul_a3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_a3), .a_i(s_a3.r), .b_i(t_a3),
    .side_i(s_a3), .valid_o(v_a4), .res_o(r1), .side_o(s_a4)
  );

  assign side2 = '{zero_in: s_a4.zero_in, h: s_a4.h, r: r1};

  // second refinement step
  logic            v_b1, v_b2, v_b3, v_b4;
  logic [31:0]     t_b1, t_b2, t_b3, r2;
  fsr_pkg::side_t  s_b1, s_b2, s_b3, s_b4;

  fsr_fmul u_mul_b1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_a4), .a_i(side2.h), .b_i(side2.r),
    .side_i(side2), .valid_o(v_b1), .res_o(t_b1), .side_o(s_b1)
  );

  fsr_fmul u_mul_b2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_b1), .a_i(t_b1), .b_i(s_b1.r),
    .side_i(s_b1), .valid_o(v_b2), .res_o(t_b2), .side_o(s_b2)
  );

  fsr_fadd u_add_b (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_b2), .a_i(fsr_pkg::ThreeHalfBits),
    .b_i({~t_b2[31], t_b2[30:0]}), .side_i(s_b2), .valid_o(v_b3), .res_o(t_b3),
    .side_o(s_b3)
  );

  fsr_fmul u_mul_b3 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_b3), .a_i(s_b3.r), .b_i(t_b3),
    .side_i(s_b3), .valid_o(v_b4), .res_o(r2), .side_o(s_b4)
  );

  // reciprocal of the refined estimate
  fsr_frcp u_rcp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_b4), .r_i(r2), .zero_in_i(s_b4.zero_in),
    .valid_o(out_valid_o), .res_o(root_bits_o)
  );

endmodule

// File: hdl/fsr_checker.sv
// fsr_checker: port-level assertions for fast_square_root_float, bound to the top
// depends on fsr_pkg and fast_square_root_float
`timescale 1ns / 1ps

module fsr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input logic [31:0]  x_bits_i,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input logic [31:0]  root_bits_o
);

  // a refused result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(root_bits_o))
    else $error("result beat changed while stalled");

  // input only backs up when the output is refused
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  // any nan result is the canonical quiet nan
  a_nan_canon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (root_bits_o[30:23] == fsr_pkg::ExpMax) && (root_bits_o[22:0] != 23'd0)
    |-> root_bits_o == fsr_pkg::QnanBits)
    else $error("non-canonical nan on output");

  // no result beat once reset has been seen at an edge
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat during reset");

endmodule

bind fast_square_root_float fsr_checker u_fsr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .x_bits_i(x_bits_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .root_bits_o(root_bits_o)
);

// File: test/fast_square_root_float_test.sv
// fast_square_root_float_test: self-checking bench for the approximate square root pipeline
// carries its own bit-exact binary32 predictor (mul, add, reciprocal, round to nearest even)
// depends on fsr_pkg and fast_square_root_float
`timescale 1ns / 1ps

module fast_square_root_float_test;

  localparam int StallLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] x_bits_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] root_bits_o;

  fast_square_root_float i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_bits_i    (x_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .root_bits_o (root_bits_o)
  );

  always #10 clk_i = ~clk_i;

  // binary32 classification
  function automatic logic f_nan(logic [31:0] b);
    return (b[30:23] == fsr_pkg::ExpMax) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(logic [31:0] b);
    return (b[30:23] == fsr_pkg::ExpMax) && (b[22:0] == 23'd0);
  endfunction

  function automatic logic f_zero(logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  // finite nonzero operand as integer significand times a power of two
  function automatic void f_split(input logic [31:0] b, output logic [63:0] sig,
                                  output int ex);
    sig = {40'd0, (b[30:23] != 8'd0), b[22:0]};
    ex  = ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
  endfunction

  // round sig * 2^ex to binary32, nearest even, with subnormals and overflow
  function automatic logic [31:0] f_round(logic s, logic [63:0] sig, int ex);
    int p, sh, ef;
    logic [63:0] q, rem, half;
    if (sig == 64'd0) return {s, 31'd0};
    p = 63;
    while (!sig[p]) p--;
    sh = p - 23;
    if (-149 - ex > sh) sh = -149 - ex;
    // far below the smallest subnormal: only stickiness remains
    if (sh > 62) begin
      sig = 64'd1;
      sh  = 2;
    end
    if (sh > 0) begin
      q    = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end else begin
      q = sig << (-sh);
    end
    ef = ex + sh;
    if (q[24]) begin
      q  = q >> 1;
      ef++;
    end
    if (!q[23]) return {s, 8'd0, q[22:0]};
    ef = ef + 150;
    if (ef >= 255) return {s, fsr_pkg::ExpMax, 23'd0};
    return {s, ef[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    logic [63:0] ma, mb;
    int ea, eb;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b) || (f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b)))
      return fsr_pkg::QnanBits;
    if (f_inf(a) || f_inf(b)) return {s, fsr_pkg::ExpMax, 23'd0};
    if (f_zero(a) || f_zero(b)) return {s, 31'd0};
    f_split(a, ma, ea);
    f_split(b, mb, eb);
    return f_round(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [63:0] ma, mb, big, lit, lost;
    int ea, eb, d;
    logic sbig, slit;
    if (f_nan(a) || f_nan(b)) return fsr_pkg::QnanBits;
    if (f_inf(a) && f_inf(b) && (a[31] != b[31])) return fsr_pkg::QnanBits;
    if (f_inf(a)) return a;
    if (f_inf(b)) return b;
    if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
    if (f_zero(a)) return b;
    if (f_zero(b)) return a;
    f_split(a, ma, ea);
    f_split(b, mb, eb);
    // larger exponent first, 30 guard bits, sticky in the lsb
    if (ea >= eb) begin
      big = ma << 30; lit = mb << 30; sbig = a[31]; slit = b[31]; d = ea - eb;
    end else begin
      big = mb << 30; lit = ma << 30; sbig = b[31]; slit = a[31]; d = eb - ea;
      ea  = eb;
    end
    if (d > 60) begin
      lit = 64'd1;
    end else begin
      lost = lit & ((64'd1 << d) - 64'd1);
      lit  = (lit >> d) | {63'd0, (lost != 64'd0)};
    end
    if (sbig == slit) return f_round(sbig, big + lit, ea - 30);
    if (big == lit) return 32'd0;
    if (big > lit) return f_round(sbig, big - lit, ea - 30);
    return f_round(slit, lit - big, ea - 30);
  endfunction

  function automatic logic [31:0] f_recip(logic [31:0] r);
    logic [63:0] m, q, rem;
    int ex;
    if (f_nan(r)) return fsr_pkg::QnanBits;
    if (f_inf(r)) return {r[31], 31'd0};
    f_split(r, m, ex);
    q   = (64'd1 << 62) / m;
    rem = (64'd1 << 62) % m;
    return f_round(r[31], q | {63'd0, (rem != 64'd0)}, -62 - ex);
  endfunction

  // expected root for one input pattern
  function automatic logic [31:0] predict_root(logic [31:0] x);
    logic [31:0] h, r, t, q;
    if (f_zero(x)) return 32'd0;
    h = f_mul(fsr_pkg::HalfBits, x);
    r = fsr_pkg::MagicConst - {x[31], x[31:1]};
    for (int k = 0; k < 2; k++) begin
      t = f_mul(h, r);
      t = f_mul(t, r);
      t = f_add(fsr_pkg::ThreeHalfBits, {~t[31], t[30:0]});
      r = f_mul(r, t);
    end
    if (f_zero(r)) return {r[31], fsr_pkg::ExpMax, 23'd0};
    q = f_recip(r);
    if (f_nan(q)) return fsr_pkg::QnanBits;
    return q;
  endfunction

  // scoreboard of expected roots in arrival order
  class root_board;
    logic [31:0] pending_roots[$];
    int          errors;

    function void note_input(logic [31:0] x);
      pending_roots.push_back(predict_root(x));
    endfunction

    function void check_root(logic [31:0] got);
      logic [31:0] want;
      if (pending_roots.size() == 0) begin
        $error("root_bits: unexpected beat, actual %h", got);
        errors++;
        return;
      end
      want = pending_roots.pop_front();
      if (got !== want) begin
        $error("root_bits: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  root_board board = new();

  // output side check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_root(root_bits_o);
  end

  // receiver stall pattern, changes mode every so often
  int stall_mode = 0;
  int stall_count = 0;
  always @(negedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_count = $urandom_range(20, 300);
    end
    stall_count--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= (stall_count % 7 < 3);
    endcase
  end

  // watchdog: busy cycles with no beat on either side
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (!in_valid_i && board.pending_roots.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // send one beat, valid stays high for the next one
  task automatic send_beat(logic [31:0] x);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    x_bits_i   <= x;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(x);
  endtask

  task automatic pause_sender(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // random operand drawn from several classes
  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5: v[30:23] = 8'($urandom_range(90, 165));
      6: v[30:23] = 8'd0;
      7: v[30:23] = ($urandom_range(0, 1) != 0) ? 8'hfe : 8'h01;
      8: v[30:23] = fsr_pkg::ExpMax;
      default: begin
        case ($urandom_range(0, 3))
          0: v[30:0] = 31'd0;
          1: v[30:0] = {fsr_pkg::ExpMax, 23'd0};
          2: v[22:0] = ($urandom_range(0, 1) != 0) ? 23'd1 : 23'h7fffff;
          default: v[30:0] = {fsr_pkg::ExpMax, 1'b1, 22'd0};
        endcase
      end
    endcase
    return v;
  endfunction

  logic [31:0] directed_ops[] = '{
    32'h00000000, 32'h80000000, 32'h3f800000, 32'h40800000, 32'h7f800000,
    32'hff800000, 32'h7fc00000, 32'hffffffff, 32'h7f800001, 32'h00000001,
    32'h007fffff, 32'h00800000, 32'h7f7fffff, 32'hff7fffff, 32'hbf800000,
    32'h80000001, 32'h3e800000, 32'h40000000, 32'h5f3759df, 32'hdf3759df,
    32'h3f000000, 32'hfffffffe, 32'h0000ffff, 32'h4b000000
  };

  int burst_left;

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed edge values
    foreach (directed_ops[k]) send_beat(directed_ops[k]);

    // random bursts with gaps
    burst_left = 0;
    for (int n = 0; n < 1730; n++) begin
      if (n == 860) begin
        // drain completely before carrying on
        pause_sender(1);
        while (board.pending_roots.size() != 0) @(negedge clk_i);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if (n > 300 && n < 500) burst_left = 200;
        else pause_sender($urandom_range(0, 6));
      end
      burst_left--;
      send_beat(random_operand());
    end
    pause_sender(1);

    // drain, then give the pipeline time for anything stray
    while (board.pending_roots.size() != 0) @(negedge clk_i);
    repeat (120) @(posedge clk_i);
    if (board.errors == 0 && board.pending_roots.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: fast_square_root_float.f
hdl/fsr_pkg.sv
hdl/fsr_fmul.sv
hdl/fsr_fadd.sv
hdl/fsr_frcp.sv
hdl/fast_square_root_float.sv
hdl/fsr_checker.sv
test/fast_square_root_float_test.sv
